// ===== src/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// Shared constants for the simple moving average block.
// ----------------------------------------------------------------------------
`default_nettype none

package sma_pkg;

    // Defaults for the top-level parameters.
    localparam int DefMaxWindow  = 64;
    localparam int DefSampleBits = 16;

    // Window length register.
    localparam int          CFG_W        = 7;
    localparam logic [6:0]  WINDOW_RESET = 7'd8;

endpackage : sma_pkg

`default_nettype wire

// ===== src/sma_cell.sv =====
// ----------------------------------------------------------------------------
// sma_cell
// One storage cell of the sample ring: takes its neighbour's value when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module sma_cell #(
    parameter int SAMPLE_BITS = sma_pkg::DefSampleBits
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire logic [SAMPLE_BITS-1:0] d,
    output logic      [SAMPLE_BITS-1:0] q
);

    logic [SAMPLE_BITS-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule : sma_cell

`default_nettype wire

// ===== src/sma_div.sv =====
// ----------------------------------------------------------------------------
// sma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sma_div #(
    parameter int DVD_W = 22,
    parameter int DIV_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign trial   = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The partial remainder always stays below the divisor, so it fits DIV_W bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[DIV_W])
            begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIV_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule : sma_div

`default_nettype wire

// ===== src/simple_moving_average.sv =====
// ----------------------------------------------------------------------------
// simple_moving_average
// Mean of the most recent window_length samples, truncated toward zero.
// ----------------------------------------------------------------------------
// Each sample transfer shifts the sample into a ring of MAX_WINDOW cells. The
// ring then rotates once all the way round, one cell per cycle, and the tail
// cell is added into an accumulator whenever it holds one of the newest
// fill-count samples; the sum is then divided by the fill count in a serial
// divider that yields one quotient bit per cycle. The next sample is taken only
// once the previous one has gone through the ring and the divider. A finished
// average waits in the output register while the next sample is taken. Before
// the window is full the mean covers the samples seen so far. A window length of
// zero means 8, and lengths above MAX_WINDOW are clipped to it; shrinking the
// window drops the oldest samples, growing it keeps the history. A window
// length write is only taken while no sample is being worked on, and it goes
// ahead of a sample that is offered in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module simple_moving_average #(
    parameter int MAX_WINDOW  = sma_pkg::DefMaxWindow,
    parameter int SAMPLE_BITS = sma_pkg::DefSampleBits
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Sample stream. tdata: sample [SAMPLE_BITS-1:0], zero padding above.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_tdata,
    // Average stream. tdata: average [SAMPLE_BITS-1:0], zero padding above.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [((SAMPLE_BITS + 7) / 8)*8-1:0] m_tdata,
    // Window length register.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [sma_pkg::CFG_W-1:0]            cfg_data
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + IDX_W;
    localparam int NW     = ((CNT_W > sma_pkg::CFG_W) ? CNT_W : sma_pkg::CFG_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_DIVS,
        ST_DIVW,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [sma_pkg::CFG_W-1:0] win_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [IDX_W-1:0]         rot_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic                     neg_reg;
    logic                     m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]   m_data_reg;

    logic                     accept;
    logic                     rotating;
    logic                     cell_en;
    logic [SAMPLE_BITS-1:0]   cell_q [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]   tail;
    logic signed [SUM_W-1:0]  tail_ext;
    logic                     tail_in_window;
    logic [CNT_W-1:0]         n_cur;
    logic [CNT_W-1:0]         n_cfg;
    logic [SUM_W-1:0]         magnitude;
    logic [SUM_W-1:0]         quotient;
    logic [SUM_W-1:0]         signed_quo;
    logic                     div_start;
    logic                     div_done;

    // Effective window: zero means the reset length, and the top end is clipped.
    function automatic logic [CNT_W-1:0] eff_window(input logic [sma_pkg::CFG_W-1:0] w);
        logic [NW-1:0] n;
        begin
            n = (w == '0) ? NW'(sma_pkg::WINDOW_RESET) : NW'(w);
            if (n > NW'(MAX_WINDOW))
            begin
                n = NW'(MAX_WINDOW);
            end
            return n[CNT_W-1:0];
        end
    endfunction

    assign n_cur     = eff_window(win_reg);
    assign n_cfg     = eff_window(cfg_data);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign rotating  = (state_reg == ST_ROT);
    assign cell_en   = accept || rotating;

    // Ring of cells: cell 0 holds the newest sample after a transfer.
    genvar k;
    generate
        for (k = 0; k < MAX_WINDOW; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                sma_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS)
                ) u_cell (
                    .clk (clk),
                    .en  (cell_en),
                    .d   (rotating ? cell_q[MAX_WINDOW-1] : s_tdata[SAMPLE_BITS-1:0]),
                    .q   (cell_q[k])
                );
            end
            else
            begin : g_body
                sma_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS)
                ) u_cell (
                    .clk (clk),
                    .en  (cell_en),
                    .d   (cell_q[k-1]),
                    .q   (cell_q[k])
                );
            end
        end
    endgenerate

    // At rotation step j the tail holds what sat in cell MAX_WINDOW-1-j; it
    // belongs to the window when that index is below the fill count.
    assign tail           = cell_q[MAX_WINDOW-1];
    assign tail_ext       = {{(SUM_W-SAMPLE_BITS){tail[SAMPLE_BITS-1]}}, tail};
    assign tail_in_window = ((CNT_W+1)'(rot_reg) + (CNT_W+1)'(fill_reg))
                            >= (CNT_W+1)'(MAX_WINDOW);

    assign magnitude  = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign div_start  = (state_reg == ST_DIVS);
    assign signed_quo = neg_reg ? (~quotient + 1'b1) : quotient;

    sma_div #(
        .DVD_W (SUM_W),
        .DIV_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (magnitude),
        .divisor  (fill_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            win_reg      <= sma_pkg::WINDOW_RESET;
            fill_reg     <= '0;
            rot_reg      <= '0;
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                win_reg <= cfg_data;
                if (fill_reg > n_cfg)
                begin
                    fill_reg <= n_cfg;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (fill_reg < n_cur)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        rot_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_ROT;
                    end
                end
                ST_ROT:
                begin
                    if (tail_in_window)
                    begin
                        acc_reg <= acc_reg + tail_ext;
                    end
                    rot_reg <= rot_reg + 1'b1;
                    if (rot_reg == IDX_W'(MAX_WINDOW - 1))
                    begin
                        state_reg <= ST_DIVS;
                    end
                end
                ST_DIVS:
                begin
                    neg_reg   <= acc_reg[SUM_W-1];
                    state_reg <= ST_DIVW;
                end
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= signed_quo[SAMPLE_BITS-1:0];
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(m_data_reg);

    // A sample transfer always starts the rotation.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_ROT))
        else $error("sample transfer did not start the ring rotation");

    // The fill count never exceeds the ring depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_WINDOW))
        else $error("fill count beyond ring depth");

    // The divider only ever runs with at least one stored sample.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (fill_reg != '0))
        else $error("divide started with zero fill count");

    // The divider finishes only while the control waits for it.
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVW))
        else $error("divider finished outside its wait state");

endmodule : simple_moving_average

`default_nettype wire
